/* hw/rtl/bzs_pkg.sv */
// Shared types, constants and arithmetic settings of the Bezier path smoother.
package bzs_pkg;

  localparam int COORD_BITS = 24;

  // The weighted sum of a curve sample plus its rounding offset stays below 2^SUM_BITS.
  localparam int SUM_BITS  = COORD_BITS + 6;
  localparam int DIV_SHIFT = SUM_BITS + 5;
  localparam int PROD_BITS = 2 * SUM_BITS + 1;

  // Adding 13 rounds to nearest; 27 * 2^COORD_BITS keeps the dividend positive and
  // only moves the quotient by 2^COORD_BITS, which falls outside the kept bits.
  localparam logic [SUM_BITS-1:0] ROUND_OFS =
    (SUM_BITS'(27) << COORD_BITS) + SUM_BITS'(13);

  // Reciprocal of 27, rounded up; exact for every dividend below 2^SUM_BITS.
  localparam logic [SUM_BITS:0] RECIP_27 =
    (SUM_BITS + 1)'(((64'd1 << DIV_SHIFT) + 64'd26) / 64'd27);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] GROUP_FULL = 2'd3;

  // Beat positions within one command.
  localparam logic [1:0] BEAT_P0 = 2'd0;
  localparam logic [1:0] BEAT_B1 = 2'd1;
  localparam logic [1:0] BEAT_B2 = 2'd2;
  localparam logic [1:0] BEAT_P3 = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef enum logic [0:0] {
    CMD_COPY,
    CMD_SEGMENT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [1:0]       beat_first;
    logic [1:0]       beat_end;
    point_t [3:0]     pts;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } queue_wr_t;

endpackage

/* hw/rtl/bzs_front.sv */
// Front end: accepts path points, keeps the point window and issues segment commands.
module bzs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [23:0]          point_x_i,
  input  logic [23:0]          point_y_i,
  input  logic                 final_point_i,
  input  logic                 queue_full_i,
  output bzs_pkg::queue_wr_t   wr_o
);

  bzs_pkg::point_t win_q [3];
  bzs_pkg::point_t win_d [3];
  logic [1:0]      gc_q, gc_d;
  logic            first_q, first_d;
  bzs_pkg::point_t pt;
  logic            accept;

  always_comb begin
    pt.x       = point_x_i;
    pt.y       = point_y_i;
    in_stall_o = queue_full_i;
    accept     = in_valid_i && !queue_full_i;

    win_d   = win_q;
    gc_d    = gc_q;
    first_d = first_q;

    wr_o.push           = 1'b0;
    wr_o.cmd.kind       = bzs_pkg::CMD_COPY;
    wr_o.cmd.beat_first = bzs_pkg::BEAT_P0;
    wr_o.cmd.beat_end   = gc_q;
    // The new point lands right after the stored ones; a full window keeps all three.
    for (int i = 0; i < 3; i++) begin
      wr_o.cmd.pts[i] = (gc_q == 2'(i)) ? pt : win_q[i];
    end
    wr_o.cmd.pts[3] = pt;

    if (accept) begin
      if (gc_q != bzs_pkg::GROUP_FULL) begin
        for (int i = 0; i < 3; i++) begin
          if (gc_q == 2'(i)) begin
            win_d[i] = pt;
          end
        end
        if (final_point_i) begin
          // A short sequence is copied through; trailing points are dropped.
          wr_o.push = first_q;
          gc_d      = 2'd0;
          first_d   = 1'b1;
        end else begin
          gc_d = gc_q + 2'd1;
        end
      end else begin
        wr_o.push           = 1'b1;
        wr_o.cmd.kind       = bzs_pkg::CMD_SEGMENT;
        wr_o.cmd.beat_first = first_q ? bzs_pkg::BEAT_P0 : bzs_pkg::BEAT_B1;
        wr_o.cmd.beat_end   = bzs_pkg::BEAT_P3;
        win_d[0]            = pt;
        gc_d                = final_point_i ? 2'd0 : 2'd1;
        first_d             = final_point_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_q    <= 2'd0;
      first_q <= 1'b1;
    end else begin
      gc_q    <= gc_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

/* hw/rtl/bzs_queue.sv */
// Command queue between the front end and the sample generator.
module bzs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bzs_pkg::queue_wr_t wr_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output bzs_pkg::cmd_t      data_o
);

  bzs_pkg::cmd_t                 mem_q [bzs_pkg::QUEUE_DEPTH];
  logic [bzs_pkg::QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [bzs_pkg::QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [bzs_pkg::QPTR_BITS:0]   count_q, count_d;

  always_comb begin
    full_o   = (count_q == (bzs_pkg::QPTR_BITS + 1)'(bzs_pkg::QUEUE_DEPTH));
    valid_o  = (count_q != '0);
    data_o   = mem_q[rd_ptr_q];
    wr_ptr_d = wr_i.push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (wr_i.push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_i.push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wr_ptr_q] <= wr_i.cmd;
    end
  end

endmodule

/* hw/rtl/bzs_back.sv */
// Back end: expands commands into output beats and computes the curve samples.
module bzs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  bzs_pkg::cmd_t q_data_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [23:0]   smooth_x_o,
  output logic [23:0]   smooth_y_o,
  output logic          run_last_o
);

  function automatic logic [bzs_pkg::SUM_BITS-1:0] weigh(
    input bzs_pkg::coord_t a,
    input bzs_pkg::coord_t b,
    input bzs_pkg::coord_t c,
    input bzs_pkg::coord_t d
  );
    logic [bzs_pkg::SUM_BITS-1:0] ea, eb, ec, ed;
    ea = bzs_pkg::SUM_BITS'(signed'(a));
    eb = bzs_pkg::SUM_BITS'(signed'(b));
    ec = bzs_pkg::SUM_BITS'(signed'(c));
    ed = bzs_pkg::SUM_BITS'(signed'(d));
    // 8a + 12b + 6c + d, biased so that the dividend is positive and rounds.
    return (ea << 3) + (eb << 3) + (eb << 2) + (ec << 2) + (ec << 1) + ed
           + bzs_pkg::ROUND_OFS;
  endfunction

  // Sequencer stage.
  bzs_pkg::cmd_t cur_q, cur_d;
  logic          cur_valid_q, cur_valid_d;
  logic [1:0]    beat_q, beat_d;
  logic          is_curve, is_last, advance;
  bzs_pkg::point_t op_a, op_b, op_c, op_d, pass_pt;

  // Sum stage.
  logic                         s1_valid_q, s1_curve_q, s1_last_q;
  logic [bzs_pkg::SUM_BITS-1:0] s1_ux_q, s1_uy_q;
  bzs_pkg::point_t              s1_pt_q;

  // Reciprocal product stage.
  logic                          s2_valid_q, s2_curve_q, s2_last_q;
  logic [bzs_pkg::PROD_BITS-1:0] s2_px_q, s2_py_q;
  bzs_pkg::point_t               s2_pt_q;

  // Output register.
  logic                   out_valid_q;
  bzs_pkg::coord_t        out_x_q, out_y_q;
  logic                   out_last_q;

  logic out_ready, s2_ready, s1_ready;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s2_ready  = !s2_valid_q || out_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;

  always_comb begin
    is_curve = (cur_q.kind == bzs_pkg::CMD_SEGMENT) &&
               ((beat_q == bzs_pkg::BEAT_B1) || (beat_q == bzs_pkg::BEAT_B2));
    is_last  = (beat_q == cur_q.beat_end);
    pass_pt  = cur_q.pts[beat_q];
    // B(2/3) uses the B(1/3) weights on the reversed control points.
    if (beat_q == bzs_pkg::BEAT_B2) begin
      op_a = cur_q.pts[3];
      op_b = cur_q.pts[2];
      op_c = cur_q.pts[1];
      op_d = cur_q.pts[0];
    end else begin
      op_a = cur_q.pts[0];
      op_b = cur_q.pts[1];
      op_c = cur_q.pts[2];
      op_d = cur_q.pts[3];
    end
    advance = cur_valid_q && s1_ready;
    q_pop_o = q_valid_i && (!cur_valid_q || (advance && is_last));

    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    beat_d      = beat_q;
    if (q_pop_o) begin
      cur_d       = q_data_i;
      cur_valid_d = 1'b1;
      beat_d      = q_data_i.beat_first;
    end else if (advance && is_last) begin
      cur_valid_d = 1'b0;
    end else if (advance) begin
      beat_d = beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      if (s1_ready) begin
        s1_valid_q <= cur_valid_q;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    beat_q <= beat_d;
    if (s1_ready) begin
      s1_curve_q <= is_curve;
      s1_last_q  <= is_last;
      s1_ux_q    <= weigh(op_a.x, op_b.x, op_c.x, op_d.x);
      s1_uy_q    <= weigh(op_a.y, op_b.y, op_c.y, op_d.y);
      s1_pt_q    <= pass_pt;
    end
    if (s2_ready) begin
      s2_curve_q <= s1_curve_q;
      s2_last_q  <= s1_last_q;
      s2_px_q    <= bzs_pkg::PROD_BITS'(s1_ux_q) * bzs_pkg::PROD_BITS'(bzs_pkg::RECIP_27);
      s2_py_q    <= bzs_pkg::PROD_BITS'(s1_uy_q) * bzs_pkg::PROD_BITS'(bzs_pkg::RECIP_27);
      s2_pt_q    <= s1_pt_q;
    end
    if (out_ready) begin
      // The low bits of the quotient are the signed sample; the bias drops out.
      out_x_q    <= s2_curve_q ? s2_px_q[bzs_pkg::DIV_SHIFT +: bzs_pkg::COORD_BITS]
                               : s2_pt_q.x;
      out_y_q    <= s2_curve_q ? s2_py_q[bzs_pkg::DIV_SHIFT +: bzs_pkg::COORD_BITS]
                               : s2_pt_q.y;
      out_last_q <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign smooth_x_o  = out_x_q;
  assign smooth_y_o  = out_y_q;
  assign run_last_o  = out_last_q;

endmodule

/* hw/rtl/cubic_bezier_path_smoother_unit.sv */
// Top level of the cubic Bezier path smoother.
// Usage:
// The input channel takes one path point per beat (signed Q15.8 x and y, plus
// final_point on the last point of a sequence). Every three points after the first
// close a cubic segment; for it the output channel gives B(1/3), B(2/3) and the
// end point, with the start point in front for the first segment of a sequence. A
// sequence of at most three points is copied through when its final point arrives.
// run_last_o marks the last beat caused by one input point.
// Commands pass the queue, then the sequencer, sum, product and output registers.
// Throughput: without receiver stalls, one output beat per cycle, set by the sample
// pipeline that computes one x/y pair per cycle. Input points are taken one per cycle
// while the four-entry command queue has room; a segment needs three output beats per
// three points, so a continuous point stream runs at one point per cycle.
// When the receiver stalls, the output beat holds, the sample pipeline fills,
// then the queue fills and in_stall_o rises.
// Reset clears the valid flags, queue pointers and point-group counter; the block then
// waits for the start of a new sequence. No clearing pass is needed.
module cubic_bezier_path_smoother_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] point_x_i,
  input  logic [23:0] point_y_i,
  input  logic        final_point_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] smooth_x_o,
  output logic [23:0] smooth_y_o,
  output logic        run_last_o
);

  bzs_pkg::queue_wr_t wr;
  bzs_pkg::cmd_t      q_data;
  logic               q_full, q_valid, q_pop;

  bzs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .final_point_i (final_point_i),
    .queue_full_i  (q_full),
    .wr_o          (wr)
  );

  bzs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  bzs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .smooth_x_o  (smooth_x_o),
    .smooth_y_o  (smooth_y_o),
    .run_last_o  (run_last_o)
  );

endmodule

/* hw/rtl/bzs_checker.sv */
// Port-level assertions for the Bezier path smoother, bound to the top level.
module bzs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [23:0] smooth_x_o,
  input logic [23:0] smooth_y_o,
  input logic        run_last_o
);

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(smooth_x_o) &&
      $stable(smooth_y_o) && $stable(run_last_o))
    else $error("output beat changed while stalled");

  // An output beat is only withdrawn after it has been taken.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("output beat dropped without being taken");

  // The input side only backs up after it has taken a beat.
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without a prior input beat");

  // Nothing is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("activity right after reset");

endmodule

bind cubic_bezier_path_smoother_unit bzs_checker u_bzs_checker (.*);
